// ===== design/lsra_pkg.sv =====
// shared constants and types for the linear scan register allocator
package lsra_pkg;

  localparam int MAX_REGS  = 16;
  localparam int REG_W     = 4;
  localparam int CNT_W     = 5;
  localparam int SLOT_BITS = 12;
  localparam int VAL_W     = 16;
  localparam int POS_W     = 16;

  localparam logic [SLOT_BITS-1:0] SLOT_MAX = {SLOT_BITS{1'b1}};

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [POS_W-1:0] end_pos;
    logic [VAL_W-1:0] value;
    logic [REG_W-1:0] reg_num;
  } entry_t;

  typedef struct packed {
    logic [VAL_W-1:0]     value_id;
    logic                 on_stack;
    logic [SLOT_BITS-1:0] loc;
    logic                 ovf;
    logic                 last;
  } result_t;

endpackage

// ===== design/linear_scan_register_allocator_core.sv =====
// linear scan register allocator: one live interval per input item
// An input item is one live interval, given in order of start. Each item first expires
// active intervals ending at or before its start, one per cycle, then either takes the
// lowest free register, takes over the register of the active interval that ends last
// (which is spilled to the next stack slot), or goes to a stack slot itself. One 16-bit
// compare unit, reading the active list through one read port, does all the expiry,
// spill and insertion-point checks. An item passes through acceptance in S_IDLE, expiry
// in S_EXPIRE, S_DECIDE, S_SPILL when no register is free and the list is not empty, an
// S_SCAN search for the insertion point in the sorted list when a register is given, and
// one emit step per result. Results leave via an output register, so the next item can
// be accepted while the last result waits.
module linear_scan_register_allocator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lsra_pkg::CNT_W-1:0]       cfg_data_i,      // num_regs
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lsra_pkg::IN_DATA_W-1:0]   s_axis_tdata,    // value_id, interval_start, interval_end
  input  logic                             s_axis_tuser,    // restart
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lsra_pkg::OUT_DATA_W-1:0]  m_axis_tdata,    // result_value_id, location_index, zero pad
  output logic [lsra_pkg::OUT_USER_W-1:0]  m_axis_tuser,    // on_stack, slot_overflow
  output logic                             m_axis_tlast
);
  import lsra_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXPIRE = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SPILL  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_EMIT0  = 3'd5;
  localparam logic [2:0] S_EMIT1  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     num_regs_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [MAX_REGS-1:0]  busy_q, busy_d;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic [REG_W-1:0]     addr_q, addr_d;
  logic [VAL_W-1:0]     val_q;
  logic [POS_W-1:0]     start_q, end_q;
  logic [REG_W-1:0]     ins_reg_q, ins_reg_d;
  logic                 two_q, two_d;
  result_t              res0_q, res0_d, res1_q, res1_d;
  result_t              out_q;
  logic                 out_valid_q;
  entry_t               act_q [MAX_REGS];

  entry_t               rd;
  logic [POS_W-1:0]     cmp_b;
  logic                 cmp_le;
  logic [CNT_W-1:0]     n_eff;
  logic                 free_found;
  logic [REG_W-1:0]     free_idx;
  logic                 slot_ovf;
  logic [SLOT_BITS-1:0] slot_inc;
  logic                 out_free;
  logic                 do_shift_down;
  logic                 do_insert;
  logic                 scan_more;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign rd     = act_q[addr_q];
  assign cmp_b  = (state_q == S_EXPIRE) ? start_q : end_q;
  assign cmp_le = (rd.end_pos <= cmp_b);

  assign n_eff = (num_regs_q > CNT_W'(MAX_REGS)) ? CNT_W'(MAX_REGS) : num_regs_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_REGS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n_eff) && !busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = REG_W'(i);
      end
    end
  end

  assign slot_ovf = (slot_q == SLOT_MAX);
  assign slot_inc = slot_ovf ? slot_q : slot_q + SLOT_BITS'(1);
  assign scan_more = ({1'b0, addr_q} < count_q) && cmp_le;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    busy_d        = busy_q;
    slot_d        = slot_q;
    addr_d        = addr_q;
    ins_reg_d     = ins_reg_q;
    two_d         = two_q;
    res0_d        = res0_q;
    res1_d        = res1_q;
    do_shift_down = 1'b0;
    do_insert     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          addr_d = '0;
          if (s_axis_tuser) begin
            count_d = '0;
            busy_d  = '0;
            slot_d  = '0;
          end
          state_d = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        if ((count_q != '0) && cmp_le) begin
          busy_d[rd.reg_num] = 1'b0;
          count_d            = count_q - CNT_W'(1);
          do_shift_down      = 1'b1;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if ((count_q < n_eff) && free_found) begin
          busy_d[free_idx] = 1'b1;
          ins_reg_d        = free_idx;
          two_d            = 1'b0;
          res0_d           = '{value_id: val_q, on_stack: 1'b0,
                               loc: SLOT_BITS'(free_idx), ovf: 1'b0, last: 1'b1};
          addr_d           = '0;
          state_d          = S_SCAN;
        end else if (count_q != '0) begin
          addr_d  = REG_W'(count_q - CNT_W'(1));
          state_d = S_SPILL;
        end else begin
          slot_d  = slot_inc;
          two_d   = 1'b0;
          res0_d  = '{value_id: val_q, on_stack: 1'b1, loc: slot_q, ovf: slot_ovf,
                      last: 1'b1};
          state_d = S_EMIT0;
        end
      end
      S_SPILL: begin
        slot_d = slot_inc;
        if (!cmp_le) begin
          ins_reg_d = rd.reg_num;
          two_d     = 1'b1;
          count_d   = count_q - CNT_W'(1);
          res0_d    = '{value_id: rd.value, on_stack: 1'b1, loc: slot_q, ovf: slot_ovf,
                        last: 1'b0};
          res1_d    = '{value_id: val_q, on_stack: 1'b0, loc: SLOT_BITS'(rd.reg_num),
                        ovf: 1'b0, last: 1'b1};
          addr_d    = '0;
          state_d   = S_SCAN;
        end else begin
          two_d   = 1'b0;
          res0_d  = '{value_id: val_q, on_stack: 1'b1, loc: slot_q, ovf: slot_ovf,
                      last: 1'b1};
          state_d = S_EMIT0;
        end
      end
      S_SCAN: begin
        if (scan_more) begin
          addr_d = addr_q + REG_W'(1);
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + CNT_W'(1);
          state_d   = S_EMIT0;
        end
      end
      S_EMIT0: begin
        if (out_free) begin
          state_d = two_q ? S_EMIT1 : S_IDLE;
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_regs_q  <= CNT_W'(MAX_REGS);
      count_q     <= '0;
      busy_q      <= '0;
      slot_q      <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      slot_q  <= slot_d;
      addr_q  <= addr_d;
      if (cfg_valid_i) begin
        num_regs_q <= cfg_data_i;
      end
      if ((state_q == S_EMIT0 || state_q == S_EMIT1) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_reg_q <= ins_reg_d;
    two_q     <= two_d;
    res0_q    <= res0_d;
    res1_q    <= res1_d;
    if (state_q == S_IDLE && s_axis_tvalid) begin
      val_q   <= s_axis_tdata[15:0];
      start_q <= s_axis_tdata[31:16];
      end_q   <= s_axis_tdata[47:32];
    end
    if (out_free) begin
      if (state_q == S_EMIT0) begin
        out_q <= res0_q;
      end else if (state_q == S_EMIT1) begin
        out_q <= res1_q;
      end
    end
  end

  // active list, sorted by end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_REGS; i++) begin
      if (do_shift_down) begin
        if (i < MAX_REGS - 1) begin
          act_q[i] <= act_q[(i < MAX_REGS - 1) ? i + 1 : i];
        end
      end else if (do_insert) begin
        if (REG_W'(i) == addr_q) begin
          act_q[i] <= '{end_pos: end_q, value: val_q, reg_num: ins_reg_q};
        end else if ((i > 0) && (REG_W'(i) > addr_q)) begin
          act_q[i] <= act_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VAL_W - SLOT_BITS){1'b0}}, out_q.loc, out_q.value_id};
  assign m_axis_tuser  = {out_q.ovf, out_q.on_stack};
  assign m_axis_tlast  = out_q.last;

endmodule
